FILE: sv/hht_pkg.sv
`default_nettype none
package hht_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int WANT_W   = 7;

	typedef enum logic {
		OP_TRACK = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_UPDATED = 2'd0,
		ST_CREATED = 2'd1,
		ST_DROPPED = 2'd2
	} status_t;

	typedef enum logic {
		KIND_TRACK  = 1'b0,
		KIND_TALKER = 1'b1
	} kind_t;

	// decoded command held in the queue
	typedef struct packed {
		op_t              op;
		logic [31:0]      ip;
		logic [15:0]      bytes;
		logic             src;
		logic [31:0]      now;
		logic [CNT_W-1:0] want;
	} cmd_t;

	// one table entry, total kept alongside for the ranking scan
	typedef struct packed {
		logic [31:0] ip;
		logic [63:0] bo;
		logic [63:0] bi;
		logic [31:0] po;
		logic [31:0] pi;
		logic [31:0] seen;
		logic [63:0] total;
	} entry_t;

	typedef struct packed {
		kind_t       kind;
		status_t     status;
		logic        ev;
		logic [31:0] ip;
		logic [63:0] bo;
		logic [63:0] bi;
		logic [31:0] po;
		logic [31:0] pi;
		logic [31:0] seen;
		logic        last;
	} res_t;

endpackage
`default_nettype wire

FILE: sv/host_traffic_table_top_n_top.sv
`default_nettype none
// Channel  Handshake             Beat
// cmd      cmd_valid/cmd_stall   op, ip_addr, byte_count, is_source, now_seconds, max_entries
// res      res_valid/res_stall   kind, status, entry_valid, entry_ip, counters, seen_time,
//                                last_of_run
// Track: one lookup read per cycle from the table memory, over the used entries.
// Query: per returned entry a full scan of totals, then a read of the winner;
// an empty query answers straight from idle, with no scan.
// Reset empties the table (fill count to zero); no clearing pass.
// A two-beat queue keeps taking commands while the engine or the result register stalls, until it is full.
module host_traffic_table_top_n_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cmd_valid,
	output logic             cmd_stall,
	input  wire logic        op,
	input  wire logic [31:0] ip_addr,
	input  wire logic [15:0] byte_count,
	input  wire logic        is_source,
	input  wire logic [31:0] now_seconds,
	input  wire logic [6:0]  max_entries,
	output logic             res_valid,
	input  wire logic        res_stall,
	output logic             kind,
	output logic [1:0]       status,
	output logic             entry_valid,
	output logic [31:0]      entry_ip,
	output logic [63:0]      sent_bytes,
	output logic [63:0]      recv_bytes,
	output logic [31:0]      sent_packets,
	output logic [31:0]      recv_packets,
	output logic [31:0]      seen_time,
	output logic             last_of_run
);
	import hht_pkg::*;

	logic head_valid, pop;
	cmd_t head;
	res_t res;

	hht_front u_front (
		.clk, .arst_n, .cmd_valid, .cmd_stall, .op, .ip_addr, .byte_count,
		.is_source, .now_seconds, .max_entries, .pop, .head_valid, .head
	);

	hht_back u_back (
		.clk, .arst_n, .head_valid, .head, .pop, .res_valid, .res_stall, .res
	);

	// unpack result beat
	assign kind         = res.kind;
	assign status       = res.status;
	assign entry_valid  = res.ev;
	assign entry_ip     = res.ip;
	assign sent_bytes   = res.bo;
	assign recv_bytes   = res.bi;
	assign sent_packets = res.po;
	assign recv_packets = res.pi;
	assign seen_time    = res.seen;
	assign last_of_run  = res.last;

endmodule
`default_nettype wire

FILE: sv/hht_front.sv
`default_nettype none
module hht_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	output logic                   cmd_stall,
	input  wire logic              op,
	input  wire logic [31:0]       ip_addr,
	input  wire logic [15:0]       byte_count,
	input  wire logic              is_source,
	input  wire logic [31:0]       now_seconds,
	input  wire logic [6:0]        max_entries,
	input  wire logic              pop,
	output logic                   head_valid,
	output hht_pkg::cmd_t          head
);
	import hht_pkg::*;

	cmd_t       fifo_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	cmd_t       cmd_in;
	logic       push;

	// classify the beat and clamp the query limit
	always_comb begin
		cmd_in.op    = op_t'(op);
		cmd_in.ip    = ip_addr;
		cmd_in.bytes = byte_count;
		cmd_in.src   = is_source;
		cmd_in.now   = now_seconds;
		if (max_entries > WANT_W'(CAPACITY))
			cmd_in.want = CNT_W'(CAPACITY);
		else
			cmd_in.want = CNT_W'(max_entries);
	end

	assign cmd_stall  = (count_q == 2'd2);
	assign push       = cmd_valid && !cmd_stall;
	assign head_valid = (count_q != 2'd0);
	assign head       = fifo_q[rd_ptr_q];

	// two-entry queue storage
	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= cmd_in;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule
`default_nettype wire

FILE: sv/hht_back.sv
`default_nettype none
module hht_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              head_valid,
	input  wire hht_pkg::cmd_t     head,
	output logic                   pop,
	output logic                   res_valid,
	input  wire logic              res_stall,
	output hht_pkg::res_t          res
);
	import hht_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_TSCAN = 5'b00010,
		S_QSCAN = 5'b00100,
		S_QREAD = 5'b01000,
		S_QEMIT = 5'b10000
	} state_t;

	state_t            state_q, state_d;
	cmd_t              cmd_q;
	logic [CNT_W-1:0]  used_q, issue_q, k_q, cnt_q;
	logic              vld_s1;
	logic [IDX_W-1:0]  idx_s1;
	entry_t            rd_s1;
	logic              best_v_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [63:0]       best_tot_q;
	logic [CAPACITY-1:0] mark_q;
	res_t              res_q;
	logic              res_valid_q;

	entry_t            mem [CAPACITY];
	logic              we, re, scan_rd;
	logic [IDX_W-1:0]  wa, ra;
	entry_t            wd, base;
	logic              out_free, more, hit, miss, q_last;
	logic [CNT_W-1:0]  q_cnt;
	res_t              res_d;
	logic              load;

	assign out_free  = !res_valid_q || !res_stall;
	assign pop       = (state_q == S_IDLE) && head_valid && out_free;
	assign more      = (issue_q < used_q);
	assign hit       = (state_q == S_TSCAN) && vld_s1 && (rd_s1.ip == cmd_q.ip);
	assign miss      = (state_q == S_TSCAN) && !vld_s1 && !more;
	assign q_cnt     = (used_q < head.want) ? used_q : head.want;
	assign q_last    = ((k_q + CNT_W'(1)) == cnt_q);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// entry update for a tracked packet, hit or fresh
	always_comb begin
		if (hit) begin
			base = rd_s1;
		end else begin
			base    = '0;
			base.ip = cmd_q.ip;
		end
		wd       = base;
		wd.seen  = cmd_q.now;
		wd.total = base.total + 64'(cmd_q.bytes);
		if (cmd_q.src) begin
			wd.bo = base.bo + 64'(cmd_q.bytes);
			wd.po = base.po + 32'd1;
		end else begin
			wd.bi = base.bi + 64'(cmd_q.bytes);
			wd.pi = base.pi + 32'd1;
		end
		we = hit || (miss && (used_q != CNT_W'(CAPACITY)));
		wa = hit ? idx_s1 : used_q[IDX_W-1:0];
	end

	// read port: scan reads or the chosen entry
	always_comb begin
		scan_rd = ((state_q == S_TSCAN) && more && !hit) ||
		          ((state_q == S_QSCAN) && more);
		re      = scan_rd || (state_q == S_QREAD);
		ra      = (state_q == S_QREAD) ? best_idx_q : issue_q[IDX_W-1:0];
	end

	// next state and result
	always_comb begin
		state_d = state_q;
		load    = 1'b0;
		res_d   = '0;
		unique case (state_q)
			S_IDLE: begin
				if (pop) begin
					if (head.op == OP_TRACK) begin
						state_d = S_TSCAN;
					end else if (q_cnt == '0) begin
						load       = 1'b1;
						res_d.kind = KIND_TALKER;
						res_d.last = 1'b1;
					end else begin
						state_d = S_QSCAN;
					end
				end
			end
			S_TSCAN: begin
				if (hit || miss) begin
					state_d    = S_IDLE;
					load       = 1'b1;
					res_d.kind = KIND_TRACK;
					res_d.last = 1'b1;
					if (hit)
						res_d.status = ST_UPDATED;
					else if (used_q == CNT_W'(CAPACITY))
						res_d.status = ST_DROPPED;
					else
						res_d.status = ST_CREATED;
				end
			end
			S_QSCAN: begin
				if (!vld_s1 && !more)
					state_d = S_QREAD;
			end
			S_QREAD: begin
				state_d = S_QEMIT;
			end
			S_QEMIT: begin
				if (out_free) begin
					load       = 1'b1;
					res_d.kind = KIND_TALKER;
					res_d.ev   = 1'b1;
					res_d.ip   = rd_s1.ip;
					res_d.bo   = rd_s1.bo;
					res_d.bi   = rd_s1.bi;
					res_d.po   = rd_s1.po;
					res_d.pi   = rd_s1.pi;
					res_d.seen = rd_s1.seen;
					res_d.last = q_last;
					state_d    = q_last ? S_IDLE : S_QSCAN;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// table memory
	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		if (re)
			rd_s1 <= mem[ra];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (pop)
			cmd_q <= head;
		if (load)
			res_q <= res_d;
		idx_s1 <= issue_q[IDX_W-1:0];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			issue_q     <= '0;
			k_q         <= '0;
			cnt_q       <= '0;
			vld_s1      <= 1'b0;
			best_v_q    <= 1'b0;
			best_idx_q  <= '0;
			best_tot_q  <= '0;
			mark_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= scan_rd;
			if (scan_rd)
				issue_q <= issue_q + CNT_W'(1);
			if (load)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
			if (miss && (used_q != CNT_W'(CAPACITY)))
				used_q <= used_q + CNT_W'(1);
			// start of an operation
			if (pop) begin
				issue_q  <= '0;
				k_q      <= '0;
				cnt_q    <= q_cnt;
				mark_q   <= '0;
				best_v_q <= 1'b0;
			end
			// ranking compare, lower index kept on ties
			if ((state_q == S_QSCAN) && vld_s1 && !mark_q[idx_s1] &&
			    (!best_v_q || (rd_s1.total > best_tot_q))) begin
				best_v_q   <= 1'b1;
				best_idx_q <= idx_s1;
				best_tot_q <= rd_s1.total;
			end
			// entry delivered, prepare next pass
			if ((state_q == S_QEMIT) && out_free) begin
				mark_q[best_idx_q] <= 1'b1;
				k_q      <= k_q + CNT_W'(1);
				issue_q  <= '0;
				best_v_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

FILE: tb/host_traffic_table_top_n_top_tb.sv
`timescale 1ns / 100ps
module host_traffic_table_top_n_top_tb;
	import hht_pkg::*;

	localparam int HANG_LIMIT = 40000;
	localparam int POOL_N     = 48;

	logic        clk;
	logic        arst_n;
	logic        cmd_valid;
	logic        cmd_stall;
	logic        op;
	logic [31:0] ip_addr;
	logic [15:0] byte_count;
	logic        is_source;
	logic [31:0] now_seconds;
	logic [6:0]  max_entries;
	logic        res_valid;
	logic        res_stall;
	logic        kind;
	logic [1:0]  status;
	logic        entry_valid;
	logic [31:0] entry_ip;
	logic [63:0] sent_bytes;
	logic [63:0] recv_bytes;
	logic [31:0] sent_packets;
	logic [31:0] recv_packets;
	logic [31:0] seen_time;
	logic        last_of_run;

	host_traffic_table_top_n_top DUT (.*);

	// shadow copy of the host table
	logic [31:0] tbl_ip   [CAPACITY];
	logic [63:0] tbl_bo   [CAPACITY];
	logic [63:0] tbl_bi   [CAPACITY];
	logic [31:0] tbl_po   [CAPACITY];
	logic [31:0] tbl_pi   [CAPACITY];
	logic [31:0] tbl_seen [CAPACITY];
	int          hosts_used;

	res_t        pending_results[$];
	logic [31:0] addr_pool[POOL_N];
	int          fail_count;
	int          beats_in;
	int          beats_out;
	int          tracks_sent;
	int          queries_sent;
	int          drops_seen;
	int          send_idle_pct;
	int          stall_pct;
	int          quiet_cycles;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// work out the results a command produces and update the shadow table
	task automatic predict_cmd(op_t c_op, logic [31:0] c_ip, logic [15:0] c_bytes,
		logic c_src, logic [31:0] c_now, logic [6:0] c_want);
		res_t r;
		int   hit;
		int   count;
		int   best;
		bit   marked[CAPACITY];
		logic [63:0] t;
		logic [63:0] best_t;
		r = '0;
		if (c_op == OP_TRACK) begin
			tracks_sent++;
			r.kind = KIND_TRACK;
			r.last = 1'b1;
			hit = -1;
			for (int i = 0; i < hosts_used; i++)
				if (hit < 0 && tbl_ip[i] == c_ip) hit = i;
			r.status = ST_UPDATED;
			if (hit < 0 && hosts_used == CAPACITY) begin
				r.status = ST_DROPPED;
				drops_seen++;
			end else begin
				if (hit < 0) begin
					hit = hosts_used++;
					tbl_ip[hit] = c_ip;
					tbl_bo[hit] = '0;
					tbl_bi[hit] = '0;
					tbl_po[hit] = '0;
					tbl_pi[hit] = '0;
					r.status = ST_CREATED;
				end
				tbl_seen[hit] = c_now;
				if (c_src) begin
					tbl_bo[hit] += c_bytes;
					tbl_po[hit] += 1;
				end else begin
					tbl_bi[hit] += c_bytes;
					tbl_pi[hit] += 1;
				end
			end
			pending_results.push_back(r);
		end else begin
			queries_sent++;
			count = (c_want > CAPACITY) ? CAPACITY : c_want;
			if (hosts_used < count) count = hosts_used;
			r.kind = KIND_TALKER;
			r.status = ST_UPDATED;
			if (count == 0) begin
				r.last = 1'b1;
				pending_results.push_back(r);
			end
			for (int i = 0; i < CAPACITY; i++) marked[i] = 1'b0;
			for (int k = 0; k < count; k++) begin
				best = -1;
				best_t = '0;
				// strict compare keeps the lower index on equal totals
				for (int i = 0; i < hosts_used; i++) begin
					t = tbl_bo[i] + tbl_bi[i];
					if (!marked[i] && (best < 0 || t > best_t)) begin
						best = i;
						best_t = t;
					end
				end
				marked[best] = 1'b1;
				r.ev   = 1'b1;
				r.ip   = tbl_ip[best];
				r.bo   = tbl_bo[best];
				r.bi   = tbl_bi[best];
				r.po   = tbl_po[best];
				r.pi   = tbl_pi[best];
				r.seen = tbl_seen[best];
				r.last = (k == count - 1);
				pending_results.push_back(r);
			end
		end
	endtask

	// send one command beat, with a random gap ahead of it
	task automatic send_cmd(op_t c_op, logic [31:0] c_ip, logic [15:0] c_bytes,
		logic c_src, logic [31:0] c_now, logic [6:0] c_want);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct && gap < 30) gap++;
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid   <= 1'b1;
		op          <= c_op;
		ip_addr     <= c_ip;
		byte_count  <= c_bytes;
		is_source   <= c_src;
		now_seconds <= c_now;
		max_entries <= c_want;
		do @(posedge clk); while (cmd_stall);
		beats_in++;
		predict_cmd(c_op, c_ip, c_bytes, c_src, c_now, c_want);
	endtask

	task automatic track(logic [31:0] a, logic [15:0] b, logic s);
		send_cmd(OP_TRACK, a, b, s, $urandom, 7'($urandom));
	endtask

	task automatic query(logic [6:0] w);
		send_cmd(OP_QUERY, $urandom, 16'($urandom), 1'($urandom_range(1)), $urandom, w);
	endtask

	task automatic test_directed();
		query(7'd0);
		query(7'd64);
		send_cmd(OP_TRACK, 32'h0, 16'h0, 1'b1, 32'h0, 7'h0);
		send_cmd(OP_TRACK, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 32'hFFFF_FFFF, 7'h7F);
		send_cmd(OP_TRACK, 32'h0, 16'hFFFF, 1'b0, 32'h5555_AAAA, 7'h0);
		send_cmd(OP_TRACK, 32'hFFFF_FFFF, 16'h1, 1'b1, 32'hAAAA_5555, 7'h0);
		// equal totals: the lower index must come out first
		track(32'h0A00_0001, 16'd100, 1'b1);
		track(32'h0A00_0002, 16'd100, 1'b0);
		track(32'h0A00_0003, 16'd50, 1'b1);
		track(32'h0A00_0003, 16'd50, 1'b0);
		query(7'd1);
		query(7'd3);
		query(7'd127);
		query(7'd65);
		query(7'd0);
		send_cmd(OP_QUERY, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 7'd64);
	endtask

	task automatic test_random(int n_items);
		for (int i = 0; i < n_items; i++) begin
			if ($urandom_range(99) < 20)
				query($urandom_range(3) == 0 ? 7'($urandom) : 7'($urandom_range(8)));
			else if ($urandom_range(99) < 70)
				track(addr_pool[$urandom_range(POOL_N - 1)], 16'($urandom),
					1'($urandom_range(1)));
			else
				track($urandom, 16'($urandom), 1'($urandom_range(1)));
		end
	endtask

	// fill every free slot, then show that a new host is dropped
	task automatic test_table_full();
		while (hosts_used < CAPACITY) track($urandom, 16'($urandom), 1'($urandom_range(1)));
		track($urandom, 16'($urandom), 1'b1);
		track($urandom, 16'($urandom), 1'b0);
		track(tbl_ip[CAPACITY - 1], 16'hFFFF, 1'b1);
		query(7'd64);
		query(7'd127);
	endtask

	task automatic set_idling(int send_pct, int stall_p);
		cmd_valid <= 1'b0;
		wait (pending_results.size() == 0);
		send_idle_pct = send_pct;
		stall_pct     = stall_p;
	endtask

	// receiver stalls and result checking
	always @(posedge clk) begin
		res_t want_r;
		res_stall <= ($urandom_range(99) < stall_pct);
		if (arst_n && res_valid && !res_stall) begin
			beats_out++;
			if (pending_results.size() == 0) begin
				$error("result beat with nothing expected");
				fail_count++;
			end else begin
				want_r = pending_results.pop_front();
				if (kind !== want_r.kind) begin
					$error("kind exp %0h got %0h", want_r.kind, kind); fail_count++;
				end
				if (status !== want_r.status) begin
					$error("status exp %0h got %0h", want_r.status, status); fail_count++;
				end
				if (entry_valid !== want_r.ev) begin
					$error("entry_valid exp %0h got %0h", want_r.ev, entry_valid);
					fail_count++;
				end
				if (entry_ip !== want_r.ip) begin
					$error("entry_ip exp %0h got %0h", want_r.ip, entry_ip); fail_count++;
				end
				if (sent_bytes !== want_r.bo) begin
					$error("sent_bytes exp %0h got %0h", want_r.bo, sent_bytes); fail_count++;
				end
				if (recv_bytes !== want_r.bi) begin
					$error("recv_bytes exp %0h got %0h", want_r.bi, recv_bytes); fail_count++;
				end
				if (sent_packets !== want_r.po) begin
					$error("sent_packets exp %0h got %0h", want_r.po, sent_packets);
					fail_count++;
				end
				if (recv_packets !== want_r.pi) begin
					$error("recv_packets exp %0h got %0h", want_r.pi, recv_packets);
					fail_count++;
				end
				if (seen_time !== want_r.seen) begin
					$error("seen_time exp %0h got %0h", want_r.seen, seen_time); fail_count++;
				end
				if (last_of_run !== want_r.last) begin
					$error("last_of_run exp %0h got %0h", want_r.last, last_of_run);
					fail_count++;
				end
			end
		end
	end

	// watchdog: too long without any beat on either channel
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= HANG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		cmd_valid     = 1'b0;
		op            = OP_TRACK;
		ip_addr       = '0;
		byte_count    = '0;
		is_source     = 1'b0;
		now_seconds   = '0;
		max_entries   = '0;
		res_stall     = 1'b0;
		arst_n        = 1'b0;
		hosts_used    = 0;
		fail_count    = 0;
		beats_in      = 0;
		beats_out     = 0;
		tracks_sent   = 0;
		queries_sent  = 0;
		drops_seen    = 0;
		quiet_cycles  = 0;
		send_idle_pct = 0;
		stall_pct     = 0;
		for (int i = 0; i < POOL_N; i++) addr_pool[i] = $urandom;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		set_idling(76, 0);
		test_random(25);
		set_idling(0, 76);
		test_random(25);
		set_idling(35, 35);
		test_random(25);
		set_idling(0, 0);
		test_random(15);
		test_table_full();
		set_idling(35, 35);
		test_random(20);

		cmd_valid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (50) @(posedge clk);
		$display("Covered %0d tracks (%0d dropped on a full table) and %0d talker queries,",
			tracks_sent, drops_seen, queries_sent);
		$display("%0d command beats in, %0d result beats checked, across four idling mixes.",
			beats_in, beats_out);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
